FILE: sv/olar_pkg.sv
`timescale 1ns / 1ps

package olar_pkg;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int POS_W    = 4;
   localparam int RSP_W    = 16;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_APPLY = 3'b010,
      S_HOLD  = 3'b100
   } state_type;

   typedef struct packed {
      logic               match_en;
      logic               apply_en;
      logic               is_remove;
      logic [VALUE_W-1:0] key;
   } cell_ctl_type;

endpackage

FILE: sv/olar_cell.sv
`timescale 1ns / 1ps

module olar_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  olar_pkg::cell_ctl_type        ctl,
   input  logic                          occupied,
   input  logic                          write_here,
   input  logic [olar_pkg::VALUE_W-1:0]  nbr_entry,
   input  logic                          found_in,
   output logic                          found_out,
   output logic                          first_hit,
   output logic [olar_pkg::VALUE_W-1:0]  entry_out
);
   import olar_pkg::*;

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic               match_ff, match_in;

   // compare against the incoming key at accept, register the flag for the update
   always_comb begin
      match_in = match_ff;
      if (ctl.match_en) begin
         match_in = occupied && (entry_ff == ctl.key);
      end
   end

   assign found_out = found_in | match_ff;
   assign first_hit = match_ff & ~found_in;
   assign entry_out = entry_ff;

   // remove: this entry and all after the hit take the right neighbor
   always_comb begin
      entry_in = entry_ff;
      if (ctl.apply_en) begin
         if (ctl.is_remove) begin
            if (found_in || match_ff) begin
               entry_in = nbr_entry;
            end
         end else if (write_here) begin
            entry_in = ctl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: sv/ordered_list_append_remove_top.sv
// Ordered list of signed 32-bit values held in insertion order.
// Input channel req_*: one transaction per operation. req_tuser is the kind
// (0 append at tail, 1 remove first entry equal to the value), req_tdata the
// value. Result channel rsp_*: one transaction per operation carrying status
// (ok, full, not found), the entry count afterwards and the position touched.
// Each entry lives in one cell of a chain. At accept every cell compares its
// entry with the value; in the apply state the first hit is resolved along the
// chain, later cells shift one place toward the head (or the first free cell takes
// an appended value) and the result is registered.
// A new operation is accepted only after the last one has been applied;
// req_tready is high again the cycle after the update.
// The result register is a separate stage: a new operation is accepted while
// an earlier result still waits; the update waits only if that result has
// not been taken, and req_tready stays low until it is.
// Reset (synchronous, active high) empties the list and drops any pending
// result; entry storage is not cleared and is never read before written.
`timescale 1ns / 1ps

module ordered_list_append_remove_top #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [6:2] entry_count, [10:7] position, pad
);
   import olar_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                kind_ff, kind_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;

   logic                req_fire, apply_go, full;
   cell_ctl_type        ctl;

   logic [VALUE_W-1:0]  entry_q   [CAPACITY];
   logic [CAPACITY-1:0] found_chain;
   logic [CAPACITY-1:0] first_hit;
   logic [IDX_W-1:0]    hit_idx;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign apply_go   = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign full       = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      ctl.match_en  = req_fire;
      ctl.apply_en  = apply_go && !(kind_ff == KIND_APPEND && full);
      ctl.is_remove = (kind_ff == KIND_REMOVE);
      ctl.key       = req_fire ? req_tdata : value_ff;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                found_prev;
      logic [VALUE_W-1:0]  nbr;
      if (i == 0) begin : g_head
         assign found_prev = 1'b0;
      end else begin : g_mid
         assign found_prev = found_chain[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign nbr = entry_q[i];
      end else begin : g_inner
         assign nbr = entry_q[i+1];
      end
      olar_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .occupied   (count_ff > CNT_W'(i)),
         .write_here (count_ff == CNT_W'(i)),
         .nbr_entry  (nbr),
         .found_in   (found_prev),
         .found_out  (found_chain[i]),
         .first_hit  (first_hit[i]),
         .entry_out  (entry_q[i])
      );
   end

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_hit[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      kind_in       = kind_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_pos_in    = rsp_pos_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               value_in = req_tdata;
               kind_in  = req_tuser;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (apply_go) begin
               rsp_valid_in = 1'b1;
               if (kind_ff == KIND_APPEND) begin
                  if (full) begin
                     rsp_status_in = STATUS_FULL;
                     rsp_pos_in    = '0;
                  end else begin
                     count_in      = count_ff + CNT_W'(1);
                     rsp_status_in = STATUS_OK;
                     rsp_pos_in    = POS_W'(count_ff);
                  end
               end else begin
                  if (found_chain[CAPACITY-1]) begin
                     count_in      = count_ff - CNT_W'(1);
                     rsp_status_in = STATUS_OK;
                     rsp_pos_in    = POS_W'(hit_idx);
                  end else begin
                     rsp_status_in = STATUS_NOT_FOUND;
                     rsp_pos_in    = '0;
                  end
               end
               rsp_count_in = COUNT_W'(count_in);
               state_in     = S_IDLE;
            end
         end
         S_HOLD: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      kind_ff       <= kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_pos_ff, rsp_count_ff, rsp_status_ff};

endmodule

FILE: sv/olar_checker.sv
`timescale 1ns / 1ps

module olar_checker #(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import olar_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("illegal status code");

   a_fail_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STATUS_OK |-> rsp_tdata[10:7] == 4'd0)
      else $error("nonzero position on failed transaction");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == STATUS_FULL |-> rsp_tdata[6:2] == COUNT_W'(CAPACITY))
      else $error("full status with wrong count");

endmodule

bind ordered_list_append_remove_top olar_checker #(.CAPACITY(CAPACITY)) u_olar_checker (.*);

FILE: sim/ordered_list_append_remove_top_test.sv
`timescale 1ns / 1ps

module ordered_list_append_remove_top_test;
   import olar_pkg::*;

   localparam int LIST_CAP = 16;
   localparam int N_RANDOM = 1425;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic [POS_W-1:0]    position;
   } list_result_type;

   typedef struct {
      logic            kind;
      logic [31:0]     value;
      bit              typed;
      list_result_type res;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic        req_tuser = 1'b0; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // [1:0] status, [6:2] entry_count, [10:7] position, pad

   ordered_list_append_remove_top #(.CAPACITY(LIST_CAP)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the list
   logic [31:0]     list_mem [LIST_CAP];
   int              list_len = 0;
   list_result_type pending_results [$];
   dir_row_type     dir_rows [$];
   int              errors = 0;
   bit              steady = 1'b0;
   int              n_append = 0, n_remove = 0, max_fill = 0, full_hits = 0;
   int              n_ok = 0, n_full = 0, n_not_found = 0;
   int              rdy_hold = 0;

   function automatic list_result_type list_apply(logic kind, logic [31:0] value);
      list_result_type r;
      int              hit;
      r   = '0;
      hit = -1;
      r.status = STATUS_OK;
      if (kind == KIND_APPEND) begin
         if (list_len >= LIST_CAP) begin
            r.status = STATUS_FULL;
         end else begin
            list_mem[list_len] = value;
            r.position = list_len[POS_W-1:0];
            list_len++;
         end
      end else begin
         for (int i = 0; i < list_len; i++)
            if (hit < 0 && list_mem[i] == value) hit = i;
         if (hit < 0) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            for (int k = hit; k < list_len - 1; k++) list_mem[k] = list_mem[k + 1];
            list_len--;
            r.position = hit[POS_W-1:0];
         end
      end
      r.entry_count = list_len[COUNT_W-1:0];
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_row(logic kind, logic [31:0] value, bit typed, list_result_type res);
      dir_row_type row;
      row.kind  = kind;
      row.value = value;
      row.typed = typed;
      row.res   = res;
      dir_rows.push_back(row);
   endtask

   // called at a rising edge; returns at a rising edge
   task automatic send_op(logic kind, logic [31:0] value, bit typed,
                          list_result_type typed_res);
      list_result_type r;
      int              gap;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = list_apply(kind, value);
      pending_results.push_back(typed ? typed_res : r);
      if (kind == KIND_APPEND) n_append++;
      else n_remove++;
      if (list_len > max_fill) max_fill = list_len;
      if (kind == KIND_APPEND && r.status == STATUS_FULL) full_hits++;
      gap = steady ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (rdy_hold > 0) begin
         rdy_hold <= rdy_hold - 1;
      end else if (steady || $urandom_range(0, 99) < 60) begin
         rsp_tready <= 1'b1;
         rdy_hold   <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b0;
         rdy_hold   <= gap_len();
      end
   end

   always @(posedge clock) begin : rsp_check
      list_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tdata[1:0];
         got.entry_count = rsp_tdata[6:2];
         got.position    = rsp_tdata[10:7];
         case (got.status)
            STATUS_OK:        n_ok++;
            STATUS_FULL:      n_full++;
            STATUS_NOT_FOUND: n_not_found++;
            default: ;
         endcase
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transaction, tdata %h", $time, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
            if (got.entry_count !== want.entry_count) begin
               errors++;
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        want.entry_count, got.entry_count);
            end
            if (got.position !== want.position) begin
               errors++;
               $display("%0t: position expected %0d actual %0d", $time,
                        want.position, got.position);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("ordered_list_append_remove_top_test failed");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] pool [8];
      int          append_pct;
      logic        kind;
      logic [31:0] value;
      int          sel;
      int          waited;

      add_row(KIND_REMOVE, 32'h0000_0000, 1, '{STATUS_NOT_FOUND, 5'd0, 4'd0});
      add_row(KIND_APPEND, 32'h8000_0000, 1, '{STATUS_OK, 5'd1, 4'd0});
      add_row(KIND_APPEND, 32'h7FFF_FFFF, 1, '{STATUS_OK, 5'd2, 4'd1});
      add_row(KIND_APPEND, 32'hFFFF_FFFF, 1, '{STATUS_OK, 5'd3, 4'd2});
      add_row(KIND_APPEND, 32'h0000_0000, 1, '{STATUS_OK, 5'd4, 4'd3});
      add_row(KIND_APPEND, 32'h7FFF_FFFF, 1, '{STATUS_OK, 5'd5, 4'd4});
      // duplicate: nearest the head goes
      add_row(KIND_REMOVE, 32'h7FFF_FFFF, 1, '{STATUS_OK, 5'd4, 4'd1});
      add_row(KIND_REMOVE, 32'h1234_5678, 1, '{STATUS_NOT_FOUND, 5'd4, 4'd0});
      for (int i = 0; i < 12; i++) add_row(KIND_APPEND, 32'h0000_1000 + i, 0, '0);
      add_row(KIND_APPEND, 32'hDEAD_BEEF, 1, '{STATUS_FULL, 5'd16, 4'd0});
      add_row(KIND_REMOVE, 32'h8000_0000, 1, '{STATUS_OK, 5'd15, 4'd0});
      add_row(KIND_REMOVE, 32'h0000_100B, 0, '0);
      add_row(KIND_REMOVE, 32'hFFFF_FFFF, 1, '{STATUS_OK, 5'd13, 4'd0});
      add_row(KIND_REMOVE, 32'hFFFF_FFFF, 1, '{STATUS_NOT_FOUND, 5'd13, 4'd0});

      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_op(dir_rows[i].kind, dir_rows[i].value,
                                    dir_rows[i].typed, dir_rows[i].res);

      pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h0000_0001, 32'h8000_0001, 32'h5555_AAAA, 32'hAAAA_5555};
      append_pct = 50;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: append_pct = 25;
               1: append_pct = 50;
               default: append_pct = 85;
            endcase
            steady = ($urandom_range(0, 4) == 0);
            pool[$urandom_range(4, 7)] = $urandom;
         end
         kind = ($urandom_range(0, 99) < append_pct) ? KIND_APPEND : KIND_REMOVE;
         sel  = $urandom_range(0, 99);
         if (kind == KIND_REMOVE && list_len > 0 && sel < 50)
            value = list_mem[$urandom_range(0, list_len - 1)];
         else if (sel < 80)
            value = pool[$urandom_range(0, 7)];
         else
            value = $urandom;
         send_op(kind, value, 0, '0);
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      waited = 0;
      while (pending_results.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      end

      $display("%0d appends, %0d removes; list peaked at %0d entries, full hit %0d times",
               n_append, n_remove, max_fill, full_hits);
      $display("results: %0d ok, %0d full, %0d not found; %0d mismatches",
               n_ok, n_full, n_not_found, errors);
      if (errors == 0) begin
         $display("ordered_list_append_remove_top_test passed");
      end else begin
         $display("ordered_list_append_remove_top_test failed");
      end
      $finish;
   end

endmodule
